// File: design/tlts_pkg.sv
package tlts_pkg;

    // Index and queue stamp widths cover the largest supported task table (64 tasks).
    localparam int TIDX_W  = 7;
    localparam int STAMP_W = 7;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_CREATE,
        ACT_TERM,
        ACT_YIELD
    } action_t;

    typedef enum logic [1:0] {
        LV_SYS,
        LV_PER,
        LV_RR,
        LV_IDLE
    } level_t;

    typedef enum logic [1:0] {
        ST_DEAD,
        ST_READY,
        ST_RUN,
        ST_WAIT
    } status_t;

    typedef enum logic {
        PH_UPDATE,
        PH_POP
    } phase_t;

    // Command broadcast from the controller to every cell during a sweep.
    typedef struct packed {
        phase_t              phase;
        action_t             action;
        logic                create_ok;
        logic                preempt;
        level_t              new_level;
        logic [15:0]         period;
        logic [15:0]         wcet;
        logic [15:0]         start;
        logic [15:0]         elapsed;
        logic                cur_valid;
        logic [TIDX_W-1:0]   cur_idx;
        logic [STAMP_W-1:0]  free_head;
        logic [STAMP_W-1:0]  free_tail;
        logic [STAMP_W-1:0]  sys_tail;
        logic [STAMP_W-1:0]  per_tail;
        logic [STAMP_W-1:0]  rr_tail;
        level_t              pop_level;
        logic [STAMP_W-1:0]  pop_head;
    } cmd_t;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic [STAMP_W-1:0]  per_tail;
        logic                made_found;
        logic [TIDX_W-1:0]   made_idx;
        logic                err;
        logic                pop_found;
        logic [TIDX_W-1:0]   pop_idx;
        level_t              pop_level;
    } tok_t;

endpackage

// File: design/tlts_cell.sv
module tlts_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [tlts_pkg::TIDX_W-1:0]  cell_idx,
    input  tlts_pkg::cmd_t               cmd,
    input  tlts_pkg::tok_t               tok_in,
    output tlts_pkg::tok_t               tok_out
);
    import tlts_pkg::*;

    status_t              status_reg, status_next;
    level_t               level_reg, level_next;
    logic [15:0]          period_reg, period_next;
    logic [15:0]          budget_reg, budget_next;
    logic [15:0]          bleft_reg, bleft_next;
    logic signed [16:0]   cnt_reg, cnt_next;
    logic                 member_reg, member_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    tok_t                 tok_reg, tok_next;

    logic                 is_cur;
    logic [STAMP_W-1:0]   own_tail;
    logic signed [16:0]   cnt_dec;

    assign is_cur  = cmd.cur_valid && (cmd.cur_idx == cell_idx);
    assign cnt_dec = cnt_reg - 17'sd1;

    // Tail stamp of the queue this task belongs to by its level.
    always_comb begin
        case (level_reg)
            LV_PER:  own_tail = cmd.per_tail;
            LV_RR:   own_tail = cmd.rr_tail;
            default: own_tail = cmd.sys_tail;
        endcase
    end

    // Local update when the token passes through this cell.
    always_comb begin
        status_next = status_reg;
        level_next  = level_reg;
        period_next = period_reg;
        budget_next = budget_reg;
        bleft_next  = bleft_reg;
        cnt_next    = cnt_reg;
        member_next = member_reg;
        stamp_next  = stamp_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            if (cmd.phase == PH_UPDATE) begin
                case (cmd.action)
                    ACT_TICK: begin
                        if (is_cur && level_reg == LV_PER) begin
                            if (bleft_reg != 16'd0) begin
                                bleft_next = bleft_reg - 16'd1;
                            end else begin
                                tok_next.err = 1'b1;
                            end
                        end
                        if (member_reg) begin
                            if (cnt_dec <= 17'sd0) begin
                                cnt_next = $signed({1'b0, period_reg});
                                if (status_reg == ST_WAIT) begin
                                    status_next       = ST_READY;
                                    stamp_next        = tok_in.per_tail;
                                    tok_next.per_tail = tok_in.per_tail + 1'b1;
                                    bleft_next        = budget_reg;
                                end
                            end else begin
                                cnt_next = cnt_dec;
                            end
                        end
                        if (is_cur && level_reg == LV_RR) begin
                            status_next = ST_READY;
                            stamp_next  = cmd.rr_tail;
                        end
                    end
                    ACT_CREATE: begin
                        if (cmd.create_ok && status_reg == ST_DEAD &&
                            stamp_reg == cmd.free_head) begin
                            level_next  = cmd.new_level;
                            period_next = cmd.period;
                            budget_next = cmd.wcet;
                            bleft_next  = cmd.wcet;
                            cnt_next    = $signed({1'b0, cmd.start}) -
                                          $signed({1'b0, cmd.elapsed});
                            if (cmd.new_level == LV_PER) begin
                                status_next = ST_WAIT;
                                member_next = 1'b1;
                            end else begin
                                status_next = ST_READY;
                                stamp_next  = (cmd.new_level == LV_SYS) ? cmd.sys_tail
                                                                       : cmd.rr_tail;
                            end
                            tok_next.made_found = 1'b1;
                            tok_next.made_idx   = cell_idx;
                        end
                        if (is_cur && cmd.preempt) begin
                            status_next = ST_READY;
                            stamp_next  = own_tail;
                        end
                    end
                    ACT_TERM: begin
                        if (is_cur) begin
                            status_next = ST_DEAD;
                            member_next = 1'b0;
                            stamp_next  = cmd.free_tail;
                        end
                    end
                    default: begin
                        if (is_cur) begin
                            if (level_reg == LV_PER) begin
                                status_next = ST_WAIT;
                            end else begin
                                status_next = ST_READY;
                                stamp_next  = own_tail;
                            end
                        end
                    end
                endcase
            end else begin
                // The head of the selected queue takes the processor.
                if (status_reg == ST_READY && level_reg == cmd.pop_level &&
                    stamp_reg == cmd.pop_head) begin
                    status_next        = ST_RUN;
                    tok_next.pop_found = 1'b1;
                    tok_next.pop_idx   = cell_idx;
                    tok_next.pop_level = level_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= (cell_idx == '0) ? ST_RUN : ST_DEAD;
            level_reg  <= LV_SYS;
            member_reg <= 1'b0;
            stamp_reg  <= STAMP_W'(cell_idx) - 1'b1;
            tok_reg    <= '0;
        end else begin
            status_reg <= status_next;
            level_reg  <= level_next;
            period_reg <= period_next;
            budget_reg <= budget_next;
            bleft_reg  <= bleft_next;
            cnt_reg    <= cnt_next;
            member_reg <= member_next;
            stamp_reg  <= stamp_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/three_level_task_scheduler.sv
// Channel  Direction  Ports                        Payload
// s_       in         s_tvalid s_tready s_tdata    one scheduler event
// m_       out        m_tvalid m_tready m_tdata    one scheduling result
//
// From acceptance to result, one sweep of the task cell chain applies the event;
// when a queued task is dispatched, a second sweep pops it. The next event is
// accepted in the cycle after the result is loaded. aresetn is synchronous, active low.
// A result waits in the output register while the next event is accepted;
// the event after that waits until the result is taken.
module three_level_task_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], new_level[3:2], new_period[19:4], new_wcet[35:20], new_start[51:36]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // running_task[3:0], create_ok[4], created_task[8:5], fault_code[10:9],
    // tick_count[26:11]
    output logic [31:0] m_tdata
);
    import tlts_pkg::*;

    localparam logic [TIDX_W-1:0]  NIL       = TIDX_W'(MAX_TASKS);
    localparam logic [TIDX_W-1:0]  PCNT_MAX  = TIDX_W'(MAX_TASKS - 1);
    localparam logic [STAMP_W-1:0] FREE_TRST = STAMP_W'(MAX_TASKS - 1);
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BUDGET = 2'd1;
    localparam logic [1:0] ERR_PCOUNT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DECIDE,
        S_POP,
        S_DONE
    } state_t;

    state_t              state_reg;
    action_t             action_reg;
    level_t              lvl_reg;
    logic [15:0]         period_reg, wcet_reg, start_reg;
    logic [15:0]         elapsed_reg;
    logic [TIDX_W-1:0]   cur_reg;
    level_t              cur_lvl_reg;
    logic [TIDX_W-1:0]   pcount_reg, pcount_next;
    logic [STAMP_W-1:0]  free_head_reg, free_tail_reg, sys_head_reg, sys_tail_reg;
    logic [STAMP_W-1:0]  per_head_reg, per_tail_reg, rr_head_reg, rr_tail_reg;
    logic [STAMP_W-1:0]  free_head_next, free_tail_next, sys_tail_next;
    logic [STAMP_W-1:0]  per_tail_next, rr_tail_next;
    logic                create_ok_reg, preempt_reg, keep_next;
    logic [1:0]          err_reg;
    logic [TIDX_W-1:0]   made_reg;
    level_t              pop_lvl_reg;
    logic [STAMP_W-1:0]  pop_head_reg;
    logic                inj_reg;
    logic                m_tvalid_reg;
    logic [31:0]         m_data_reg;

    logic                cur_valid;
    logic                in_accept;
    action_t             in_action;
    level_t              in_level;
    logic                pcount_full;
    logic                in_create_ok;
    logic                requeue;
    cmd_t                cmd;
    tok_t                tok_first;
    tok_t                tok_chain [0:MAX_TASKS];
    tok_t                tok_last;

    assign cur_valid   = (cur_reg != NIL);
    assign in_accept   = s_tvalid && s_tready;
    assign in_action   = action_t'(s_tdata[1:0]);
    assign in_level    = level_t'(s_tdata[3:2]);
    assign pcount_full = (pcount_reg >= PCNT_MAX);
    assign in_create_ok = (in_action == ACT_CREATE) && (in_level != LV_IDLE) &&
                          !(in_level == LV_PER && pcount_full) &&
                          (free_head_reg != free_tail_reg);
    assign s_tready    = (state_reg == S_IDLE);
    assign tok_last    = tok_chain[MAX_TASKS];

    // Broadcast command held stable while a token crosses the chain.
    always_comb begin
        cmd.phase     = (state_reg == S_POP) ? PH_POP : PH_UPDATE;
        cmd.action    = action_reg;
        cmd.create_ok = create_ok_reg;
        cmd.preempt   = preempt_reg;
        cmd.new_level = lvl_reg;
        cmd.period    = period_reg;
        cmd.wcet      = wcet_reg;
        cmd.start     = start_reg;
        cmd.elapsed   = elapsed_reg;
        cmd.cur_valid = cur_valid;
        cmd.cur_idx   = cur_reg;
        cmd.free_head = free_head_reg;
        cmd.free_tail = free_tail_reg;
        cmd.sys_tail  = sys_tail_reg;
        cmd.per_tail  = per_tail_reg;
        cmd.rr_tail   = rr_tail_reg;
        cmd.pop_level = pop_lvl_reg;
        cmd.pop_head  = pop_head_reg;
    end

    // Token injected at the head of the chain.
    always_comb begin
        tok_first          = '0;
        tok_first.valid    = inj_reg;
        tok_first.per_tail = per_tail_reg;
    end

    assign tok_chain[0] = tok_first;

    // Row of task cells, one per descriptor.
    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        tlts_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (TIDX_W'(i)),
            .cmd      (cmd),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_chain[i+1])
        );
    end

    // Queue bookkeeping once the update sweep has returned.
    always_comb begin
        requeue = cur_valid &&
                  ((action_reg == ACT_TICK && cur_lvl_reg == LV_RR) ||
                   (action_reg == ACT_CREATE && preempt_reg) ||
                   (action_reg == ACT_YIELD && cur_lvl_reg != LV_PER));
        sys_tail_next  = sys_tail_reg +
                         STAMP_W'(requeue && cur_lvl_reg == LV_SYS) +
                         STAMP_W'(create_ok_reg && lvl_reg == LV_SYS);
        rr_tail_next   = rr_tail_reg +
                         STAMP_W'(requeue && cur_lvl_reg == LV_RR) +
                         STAMP_W'(create_ok_reg && lvl_reg == LV_RR);
        per_tail_next  = tok_last.per_tail + STAMP_W'(requeue && cur_lvl_reg == LV_PER);
        free_head_next = free_head_reg + STAMP_W'(create_ok_reg);
        free_tail_next = free_tail_reg + STAMP_W'(action_reg == ACT_TERM && cur_valid);
        pcount_next    = pcount_reg;
        if (create_ok_reg && lvl_reg == LV_PER) begin
            pcount_next = pcount_reg + 1'b1;
        end else if (action_reg == ACT_TERM && cur_valid && cur_lvl_reg == LV_PER &&
                     pcount_reg != '0) begin
            pcount_next = pcount_reg - 1'b1;
        end
        case (action_reg)
            ACT_TICK:   keep_next = cur_valid && (cur_lvl_reg != LV_RR);
            ACT_CREATE: keep_next = cur_valid && !preempt_reg;
            default:    keep_next = 1'b0;
        endcase
    end

    // Sequencer with the registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            inj_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            cur_reg       <= '0;
            cur_lvl_reg   <= LV_SYS;
            elapsed_reg   <= '0;
            pcount_reg    <= '0;
            free_head_reg <= '0;
            free_tail_reg <= FREE_TRST;
            sys_head_reg  <= '0;
            sys_tail_reg  <= '0;
            per_head_reg  <= '0;
            per_tail_reg  <= '0;
            rr_head_reg   <= '0;
            rr_tail_reg   <= '0;
        end else begin
            if (m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    inj_reg <= in_accept;
                    if (in_accept) begin
                        action_reg    <= in_action;
                        lvl_reg       <= in_level;
                        period_reg    <= s_tdata[19:4];
                        wcet_reg      <= s_tdata[35:20];
                        start_reg     <= s_tdata[51:36];
                        create_ok_reg <= in_create_ok;
                        preempt_reg   <= in_create_ok && cur_valid &&
                            ((in_level == LV_SYS && cur_lvl_reg != LV_SYS) ||
                             (in_level == LV_PER && cur_lvl_reg == LV_RR &&
                              s_tdata[51:36] == elapsed_reg));
                        err_reg       <= (in_action == ACT_CREATE && in_level == LV_PER &&
                                          pcount_full) ? ERR_PCOUNT : ERR_NONE;
                        if (in_action == ACT_TICK) begin
                            elapsed_reg <= elapsed_reg + 16'd1;
                        end
                        state_reg     <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    inj_reg <= 1'b0;
                    if (tok_last.valid) begin
                        if (tok_last.err) begin
                            err_reg <= ERR_BUDGET;
                        end
                        made_reg      <= tok_last.made_found ? tok_last.made_idx : '0;
                        sys_tail_reg  <= sys_tail_next;
                        per_tail_reg  <= per_tail_next;
                        rr_tail_reg   <= rr_tail_next;
                        free_head_reg <= free_head_next;
                        free_tail_reg <= free_tail_next;
                        pcount_reg    <= pcount_next;
                        state_reg     <= keep_next ? S_DONE : S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (sys_head_reg != sys_tail_reg) begin
                        pop_lvl_reg  <= LV_SYS;
                        pop_head_reg <= sys_head_reg;
                        sys_head_reg <= sys_head_reg + 1'b1;
                        inj_reg      <= 1'b1;
                        state_reg    <= S_POP;
                    end else if (per_head_reg != per_tail_reg) begin
                        pop_lvl_reg  <= LV_PER;
                        pop_head_reg <= per_head_reg;
                        per_head_reg <= per_head_reg + 1'b1;
                        inj_reg      <= 1'b1;
                        state_reg    <= S_POP;
                    end else if (rr_head_reg != rr_tail_reg) begin
                        pop_lvl_reg  <= LV_RR;
                        pop_head_reg <= rr_head_reg;
                        rr_head_reg  <= rr_head_reg + 1'b1;
                        inj_reg      <= 1'b1;
                        state_reg    <= S_POP;
                    end else begin
                        cur_reg     <= NIL;
                        cur_lvl_reg <= LV_IDLE;
                        inj_reg     <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                end
                S_POP: begin
                    inj_reg <= 1'b0;
                    if (tok_last.valid) begin
                        cur_reg     <= tok_last.pop_idx;
                        cur_lvl_reg <= tok_last.pop_level;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE: begin
                    inj_reg <= 1'b0;
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= {5'd0, elapsed_reg, err_reg,
                                         create_ok_reg ? 4'(made_reg) : 4'd0,
                                         create_ok_reg, 4'(cur_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    inj_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A token only leaves the chain during a sweep.
    a_token_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.valid |-> (state_reg == S_UPDATE || state_reg == S_POP))
        else $error("token left the cell chain outside a sweep");

    // Popping a non-empty queue always finds its head cell.
    a_pop_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP && tok_last.valid) |-> tok_last.pop_found)
        else $error("queue head not found in cell chain");

    // Periodic task count stays within the table.
    a_pcount: assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg <= PCNT_MAX)
        else $error("periodic task count overflow");

    // The running task is a descriptor or idle.
    a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= NIL)
        else $error("running task index out of range");
`endif

endmodule
